[src/wfold_pkg.sv]
// wfold_pkg: shared types, constants and lookup functions of the width folder
// depends on nothing; imported by every module of the block
package wfold_pkg;

  // code ranges and special units
  localparam logic [15:0] FwFirst     = 16'hFF01;
  localparam logic [15:0] FwAsciiLast = 16'hFF5E;
  localparam logic [15:0] KanaFirst   = 16'hFF5F;
  localparam logic [15:0] KanaLast    = 16'hFF9F;
  localparam logic [15:0] HangulLast  = 16'hFFDF;
  localparam logic [15:0] MiscFirst   = 16'hFFE0;
  localparam logic [15:0] FwLast      = 16'hFFEE;
  localparam logic [15:0] MarkVoiced  = 16'hFF9E;
  localparam logic [15:0] MarkSemi    = 16'hFF9F;
  localparam logic [15:0] KaFirst     = 16'hFF76;
  localparam logic [15:0] KaLast      = 16'hFF84;
  localparam logic [15:0] HaFirst     = 16'hFF8A;
  localparam logic [15:0] HaLast      = 16'hFF8E;
  localparam logic [15:0] BaseU       = 16'hFF73;
  localparam logic [15:0] BaseWa      = 16'hFF9C;
  localparam logic [15:0] BaseWo      = 16'hFF66;
  localparam logic [15:0] VoicedU     = 16'h30F4;
  localparam logic [15:0] VoicedWa    = 16'h30F7;
  localparam logic [15:0] VoicedWo    = 16'h30FA;
  // fullwidth ascii: c - 0xFF01 + 0x21 == c - 0xFEE0
  localparam logic [15:0] FwAsciiOffset = 16'hFEE0;

  // result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // halfwidth punctuation and katakana to wide forms
  localparam logic [15:0] NarrowKana [65] = '{
    16'h0028, 16'h0029, 16'h3002, 16'h300C, 16'h300D, 16'h3001, 16'h30FB, 16'h30F2,
    16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9, 16'h30E3, 16'h30E5, 16'h30E7,
    16'h30C3, 16'h30FC, 16'h30A2, 16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA, 16'h30AB,
    16'h30AD, 16'h30AF, 16'h30B1, 16'h30B3, 16'h30B5, 16'h30B7, 16'h30B9, 16'h30BB,
    16'h30BD, 16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8, 16'h30CA, 16'h30CB,
    16'h30CC, 16'h30CD, 16'h30CE, 16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8, 16'h30DB,
    16'h30DE, 16'h30DF, 16'h30E0, 16'h30E1, 16'h30E2, 16'h30E4, 16'h30E6, 16'h30E8,
    16'h30E9, 16'h30EA, 16'h30EB, 16'h30EC, 16'h30ED, 16'h30EF, 16'h30F3, 16'h3099,
    16'h309A
  };

  localparam logic [15:0] VoicedKa [15] = '{
    16'h30AC, 16'h30AE, 16'h30B0, 16'h30B2, 16'h30B4, 16'h30B6, 16'h30B8, 16'h30BA,
    16'h30BC, 16'h30BE, 16'h30C0, 16'h30C2, 16'h30C5, 16'h30C7, 16'h30C9
  };

  localparam logic [15:0] VoicedHa [5] = '{16'h30D0, 16'h30D3, 16'h30D6, 16'h30D9, 16'h30DC};
  localparam logic [15:0] SemiHa   [5] = '{16'h30D1, 16'h30D4, 16'h30D7, 16'h30DA, 16'h30DD};

  // one result item
  typedef struct packed {
    logic [15:0] out_unit;
    logic        present;
    logic        last_result;
  } res_t;

  // everything one step produces
  typedef struct packed {
    res_t        res0;
    res_t        res1;
    logic        push0;
    logic        push1;
    logic        hold_valid;
    logic [15:0] hold_unit;
  } step_t;

  // misc fullwidth forms, FFE0..FFEE by low nibble
  function automatic logic [15:0] misc_form(input logic [3:0] idx);
    logic [15:0] r;
    case (idx)
      4'h0:    r = 16'h00A2;
      4'h1:    r = 16'h00A3;
      4'h2:    r = 16'h00AC;
      4'h3:    r = 16'h00AF;
      4'h4:    r = 16'h00A6;
      4'h5:    r = 16'h00A5;
      4'h6:    r = 16'h20A9;
      4'h7:    r = 16'hFFE7;
      4'h8:    r = 16'h2502;
      4'h9:    r = 16'h2190;
      4'hA:    r = 16'h2191;
      4'hB:    r = 16'h2192;
      4'hC:    r = 16'h2193;
      4'hD:    r = 16'h25A0;
      4'hE:    r = 16'h25CB;
      default: r = 16'hFFEF;
    endcase
    return r;
  endfunction

  // width fold of a single unit
  function automatic logic [15:0] fold_one(input logic [15:0] c);
    logic [7:0]  kidx;
    logic [15:0] r;
    kidx = c[7:0] - KanaFirst[7:0];
    if (c < FwFirst || c > FwLast)  r = c;
    else if (c <= FwAsciiLast)      r = c - FwAsciiOffset;
    else if (c <= KanaLast)         r = NarrowKana[kidx[6:0]];
    else if (c <= HangulLast)       r = c;
    else                            r = misc_form(c[3:0]);
    return r;
  endfunction

  // katakana base that may take a following mark
  function automatic logic is_base(input logic [15:0] c);
    return (c >= KaFirst && c <= KaLast) || (c >= HaFirst && c <= HaLast) ||
           c == BaseU || c == BaseWa || c == BaseWo;
  endfunction

  // precomposed unit for base and mark, zero when the pair is not listed
  function automatic logic [15:0] merge_pair(input logic [15:0] b, input logic [15:0] m);
    logic [7:0]  ka_idx;
    logic [7:0]  ha_idx;
    logic [15:0] r;
    ka_idx = b[7:0] - KaFirst[7:0];
    ha_idx = b[7:0] - HaFirst[7:0];
    r = '0;
    if (m == MarkVoiced) begin
      if (b >= KaFirst && b <= KaLast)      r = VoicedKa[ka_idx[3:0]];
      else if (b >= HaFirst && b <= HaLast) r = VoicedHa[ha_idx[2:0]];
      else if (b == BaseU)                  r = VoicedU;
      else if (b == BaseWa)                 r = VoicedWa;
      else if (b == BaseWo)                 r = VoicedWo;
    end else if (m == MarkSemi) begin
      if (b >= HaFirst && b <= HaLast)      r = SemiHa[ha_idx[2:0]];
    end
    return r;
  endfunction

endpackage

[src/wfold_step.sv]
// wfold_step: combinational fold of one item against the held katakana base
// depends on wfold_pkg (types and lookup functions)
module wfold_step import wfold_pkg::*; (
  input  logic        held_valid_i,
  input  logic [15:0] held_unit_i,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output step_t       step_o
);

  logic [15:0] merged_unit;
  logic [15:0] held_fold;
  logic [15:0] new_fold;
  logic        merged;
  logic        emit_held;
  logic        is_zero;
  logic        hold_new;
  logic        emit_new;
  logic        marker;

  // decide what this item produces
  always_comb begin
    merged_unit = merge_pair(held_unit_i, code_unit_i);
    held_fold   = fold_one(held_unit_i);
    new_fold    = fold_one(code_unit_i);
    merged      = held_valid_i && (merged_unit != '0);
    emit_held   = held_valid_i && !merged;
    is_zero     = (code_unit_i == '0);
    hold_new    = !merged && !is_zero && is_base(code_unit_i) && !last_unit_i;
    emit_new    = !merged && !is_zero && !hold_new;
    marker      = !merged && !held_valid_i && is_zero && last_unit_i;
  end

  // pack the up to two results
  always_comb begin
    step_o = '0;
    if (merged) begin
      step_o.res0 = '{out_unit: merged_unit, present: 1'b1, last_result: last_unit_i};
    end else if (emit_held) begin
      step_o.res0 = '{out_unit: held_fold, present: 1'b1,
                      last_result: is_zero && last_unit_i};
    end else if (marker) begin
      step_o.res0 = '{out_unit: 16'h0000, present: 1'b0, last_result: 1'b1};
    end else begin
      step_o.res0 = '{out_unit: new_fold, present: 1'b1, last_result: last_unit_i};
    end
    step_o.res1       = '{out_unit: new_fold, present: 1'b1, last_result: last_unit_i};
    step_o.push0      = merged || emit_held || marker || emit_new;
    step_o.push1      = emit_held && emit_new;
    step_o.hold_valid = hold_new;
    step_o.hold_unit  = code_unit_i;
  end

endmodule

[src/wfold_outq.sv]
// wfold_outq: small result queue, takes up to two items a cycle, gives one
// depends on wfold_pkg (res_t, queue geometry)
module wfold_outq import wfold_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push0_i,
  input  logic push1_i,
  input  res_t res0_i,
  input  res_t res1_i,
  output logic space_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t head_o
);

  res_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAw:0]     count_q, count_d;
  logic [QAw-1:0]   wr_ptr_nxt;
  logic             pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign head_o      = mem_q[rd_ptr_q];
  // room for the worst case of two results
  assign space_o     = (count_q <= (QAw+1)'(QDepth - 2));
  assign wr_ptr_nxt  = wr_ptr_q + QAw'(1);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + QAw'(push0_i) + QAw'(push1_i);
    rd_ptr_d = rd_ptr_q + QAw'(pop);
    count_d  = count_q + (QAw+1)'(push0_i) + (QAw+1)'(push1_i) - (QAw+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_nxt] <= res1_i;
    end
  end

  // second write slot only used together with the first
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i)
    else $error("second result pushed without first");

  // writes only land when there was room for two
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push0_i |-> space_o)
    else $error("result queue written without room");

  // fill level tracks pushes and pops
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push0_i && !pop) |=> count_q == $past(count_q))
    else $error("result queue count moved without traffic");

endmodule

[src/fullwidth_halfwidth_folder_core.sv]
// fullwidth_halfwidth_folder_core: top level of the unicode width folder
// depends on wfold_pkg, wfold_step and wfold_outq
//
// Takes one UTF-16 code unit per cycle and emits the width-folded stream:
// fullwidth ascii becomes ascii, halfwidth katakana and punctuation become
// wide forms, a katakana base followed by a listed (semi-)voicing mark is
// merged into one precomposed unit, misc fullwidth forms are mapped, zero
// units are dropped. An item is registered on input and then folded into a
// four-entry result queue once the queue has room for two results; a result
// is offered on the output from the head of that queue. One item is accepted
// per cycle while results drain at least as fast as they arrive; an item
// that yields two results (a held base that does not merge, plus the new
// unit) puts one extra result into the queue, and the input stalls only
// when an item waits in the input register and the queue lacks room for two
// results. A mergeable base that is not the last unit waits for the next
// unit before its result is emitted; a string that ends with nothing to
// carry the last flag gets an end marker with present low.
module fullwidth_halfwidth_folder_core import wfold_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_unit_o,
  output logic        present_o,
  output logic        last_result_o
);

  logic        s1_valid_q, s1_valid_d;
  logic [15:0] s1_unit_q;
  logic        s1_last_q;
  logic        held_valid_q, held_valid_d;
  logic [15:0] held_unit_q, held_unit_d;
  logic        space;
  logic        proc;
  logic        in_acc;
  step_t       step;
  res_t        head;

  // input stage handshake
  assign proc       = s1_valid_q && space;
  assign in_ready_o = !s1_valid_q || proc;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (proc) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_unit_q <= code_unit_i;
      s1_last_q <= last_unit_i;
    end
  end

  // fold logic
  wfold_step u_step (
    .held_valid_i (held_valid_q),
    .held_unit_i  (held_unit_q),
    .code_unit_i  (s1_unit_q),
    .last_unit_i  (s1_last_q),
    .step_o       (step)
  );

  // lookahead base register
  always_comb begin
    held_valid_d = held_valid_q;
    held_unit_d  = held_unit_q;
    if (proc) begin
      held_valid_d = step.hold_valid;
      if (step.hold_valid) begin
        held_unit_d = step.hold_unit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_unit_q  <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_unit_q  <= held_unit_d;
    end
  end

  // result queue
  wfold_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (proc && step.push0),
    .push1_i     (proc && step.push1),
    .res0_i      (step.res0),
    .res1_i      (step.res1),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign out_unit_o    = head.out_unit;
  assign present_o     = head.present;
  assign last_result_o = head.last_result;

  // nothing stays held past the end of a string
  a_last_clears_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && s1_last_q) |=> !held_valid_q)
    else $error("base still held after last item");

  // only a katakana base is ever held
  a_held_is_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> is_base(held_unit_q))
    else $error("held unit is not a mergeable base");

  // an item that produces nothing must leave a base held
  a_silent_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !step.push0 && s1_unit_q != '0) |=> held_valid_q)
    else $error("item dropped without being held");

endmodule

[tb/wfold_checker.sv]
// wfold_checker: watches both channels of the width folder, predicts each result and compares
// depends on wfold_pkg for the result item type
module wfold_checker import wfold_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] out_unit_i,
  input  logic        present_i,
  input  logic        last_result_i,
  output int          error_count_o,
  output int          pending_o
);

  // wide forms of ff5f..ff9f, first entry in the top bits
  localparam logic [65*16-1:0] KanaWide = {
    16'h0028, 16'h0029, 16'h3002, 16'h300C, 16'h300D, 16'h3001, 16'h30FB, 16'h30F2,
    16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9, 16'h30E3, 16'h30E5, 16'h30E7,
    16'h30C3, 16'h30FC, 16'h30A2, 16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA, 16'h30AB,
    16'h30AD, 16'h30AF, 16'h30B1, 16'h30B3, 16'h30B5, 16'h30B7, 16'h30B9, 16'h30BB,
    16'h30BD, 16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8, 16'h30CA, 16'h30CB,
    16'h30CC, 16'h30CD, 16'h30CE, 16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8, 16'h30DB,
    16'h30DE, 16'h30DF, 16'h30E0, 16'h30E1, 16'h30E2, 16'h30E4, 16'h30E6, 16'h30E8,
    16'h30E9, 16'h30EA, 16'h30EB, 16'h30EC, 16'h30ED, 16'h30EF, 16'h30F3, 16'h3099,
    16'h309A
  };

  // voiced forms of the ka..to bases ff76..ff84
  localparam logic [15*16-1:0] KaVoicedWide = {
    16'h30AC, 16'h30AE, 16'h30B0, 16'h30B2, 16'h30B4, 16'h30B6, 16'h30B8, 16'h30BA,
    16'h30BC, 16'h30BE, 16'h30C0, 16'h30C2, 16'h30C5, 16'h30C7, 16'h30C9
  };

  // voiced and semi-voiced forms of the ha..ho bases ff8a..ff8e
  localparam logic [5*16-1:0] HaVoicedWide = {
    16'h30D0, 16'h30D3, 16'h30D6, 16'h30D9, 16'h30DC
  };
  localparam logic [5*16-1:0] HaSemiWide = {
    16'h30D1, 16'h30D4, 16'h30D7, 16'h30DA, 16'h30DD
  };

  // misc fullwidth forms ffe0..ffee
  localparam logic [15*16-1:0] MiscWide = {
    16'h00A2, 16'h00A3, 16'h00AC, 16'h00AF, 16'h00A6, 16'h00A5, 16'h20A9, 16'hFFE7,
    16'h2502, 16'h2190, 16'h2191, 16'h2192, 16'h2193, 16'h25A0, 16'h25CB
  };

  res_t        expected_results[$];
  logic [15:0] held_unit;
  logic        held_valid;
  int          errors = 0;

  // append one expected result item at the tail
  function automatic void queue_expected(input res_t r);
    expected_results = {expected_results, r};
  endfunction

  // width fold of one unit on its own
  function automatic logic [15:0] width_fold(input logic [15:0] c);
    int          idx;
    logic [15:0] r;
    idx = 0;
    if (c < 16'hFF01 || c > 16'hFFEE) begin
      r = c;
    end else if (c <= 16'hFF5E) begin
      r = c - 16'hFEE0;
    end else if (c <= 16'hFF9F) begin
      idx = c - 16'hFF5F;
      r = KanaWide[(64 - idx)*16 +: 16];
    end else if (c <= 16'hFFDF) begin
      r = c;
    end else begin
      idx = c - 16'hFFE0;
      r = MiscWide[(14 - idx)*16 +: 16];
    end
    return r;
  endfunction

  // expected results of one accepted item, with the lookahead state
  task automatic fold_item(input logic [15:0] c, input logic lu);
    logic [15:0] merged;
    res_t        flushed;
    logic        have_flush;
    int          b_idx;
    merged     = '0;
    flushed    = '0;
    have_flush = 1'b0;
    b_idx      = 0;
    // a held base either merges with this unit or is flushed ahead of it
    if (held_valid) begin
      held_valid = 1'b0;
      if (c == 16'hFF9E) begin
        if (held_unit >= 16'hFF76 && held_unit <= 16'hFF84) begin
          b_idx = held_unit - 16'hFF76;
          merged = KaVoicedWide[(14 - b_idx)*16 +: 16];
        end else if (held_unit >= 16'hFF8A && held_unit <= 16'hFF8E) begin
          b_idx = held_unit - 16'hFF8A;
          merged = HaVoicedWide[(4 - b_idx)*16 +: 16];
        end else if (held_unit == 16'hFF73) begin
          merged = 16'h30F4;
        end else if (held_unit == 16'hFF9C) begin
          merged = 16'h30F7;
        end else if (held_unit == 16'hFF66) begin
          merged = 16'h30FA;
        end
      end else if (c == 16'hFF9F && held_unit >= 16'hFF8A && held_unit <= 16'hFF8E) begin
        b_idx = held_unit - 16'hFF8A;
        merged = HaSemiWide[(4 - b_idx)*16 +: 16];
      end
      if (merged == '0) begin
        flushed    = {width_fold(held_unit), 1'b1, 1'b0};
        have_flush = 1'b1;
      end
    end

    if (merged != '0) begin
      queue_expected({merged, 1'b1, lu});
    end else if (c == '0) begin
      // zero unit dropped; the end flag rides on a flushed base or an end marker
      if (have_flush) queue_expected({flushed.out_unit, 1'b1, lu});
      else if (lu) queue_expected({16'h0000, 1'b0, 1'b1});
    end else begin
      if (have_flush) queue_expected(flushed);
      if (!lu && ((c >= 16'hFF76 && c <= 16'hFF84) || (c >= 16'hFF8A && c <= 16'hFF8E) ||
                  c == 16'hFF73 || c == 16'hFF9C || c == 16'hFF66)) begin
        held_unit  = c;
        held_valid = 1'b1;
      end else begin
        queue_expected({width_fold(c), 1'b1, lu});
      end
    end
  endtask

  // predict on input items, compare on result items
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      expected_results.delete();
      held_unit  = '0;
      held_valid = 1'b0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) fold_item(code_unit_i, last_unit_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: out_unit %h present %b last_result %b",
                 out_unit_i, present_i, last_result_i);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_unit_i !== want.out_unit) begin
            $error("out_unit: expected %h, actual %h", want.out_unit, out_unit_i);
            errors++;
          end
          if (present_i !== want.present) begin
            $error("present: expected %b, actual %b", want.present, present_i);
            errors++;
          end
          if (last_result_i !== want.last_result) begin
            $error("last_result: expected %b, actual %b", want.last_result, last_result_i);
            errors++;
          end
        end
      end
      pending_o <= expected_results.size();
    end
    error_count_o <= errors;
  end

endmodule

[tb/tb_fullwidth_halfwidth_folder_core.sv]
// tb_fullwidth_halfwidth_folder_core: stimulus and verdict for the width folder
// depends on wfold_pkg, fullwidth_halfwidth_folder_core and wfold_checker
module tb_fullwidth_halfwidth_folder_core import wfold_pkg::*;;

  typedef enum int {IdleNone, IdleFull, IdleSparse} idle_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] code_unit;
  logic        last_unit;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_unit;
  logic        present;
  logic        last_result;
  int          error_count;
  int          pending_results;

  int          units_sent = 0;
  int          results_taken = 0;
  logic        long_hold_done = 1'b0;
  idle_mode_e  send_mode = IdleFull;
  idle_mode_e  recv_mode = IdleSparse;

  always #5 clk = ~clk;

  fullwidth_halfwidth_folder_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .code_unit_i   (code_unit),
    .last_unit_i   (last_unit),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_unit_o    (out_unit),
    .present_o     (present),
    .last_result_o (last_result)
  );

  wfold_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .code_unit_i   (code_unit),
    .last_unit_i   (last_unit),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_unit_i    (out_unit),
    .present_i     (present),
    .last_result_i (last_result),
    .error_count_o (error_count),
    .pending_o     (pending_results)
  );

  // idle cycles before one item, by the current mode of that side
  function automatic int draw_gap(input idle_mode_e mode);
    int gap;
    case (mode)
      IdleNone: gap = 0;
      IdleFull: gap = $urandom_range(0, 15);
      default:  gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
    endcase
    return gap;
  endfunction

  // offer one code unit and wait for it to be taken
  task automatic send_unit(input logic [15:0] cu, input logic lu);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_unit <= cu;
    last_unit <= lu;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    units_sent++;
    if (units_sent % 64 == 0) send_mode = idle_mode_e'($urandom_range(0, 2));
  endtask

  // a mergeable katakana base
  function automatic logic [15:0] pick_base();
    logic [15:0] b;
    case ($urandom_range(0, 3))
      0:       b = 16'hFF76 + 16'($urandom_range(0, 14));
      1:       b = 16'hFF8A + 16'($urandom_range(0, 4));
      2:       b = BaseU;
      default: b = ($urandom_range(0, 1) == 0) ? BaseWa : BaseWo;
    endcase
    return b;
  endfunction

  // one unit of random text, weighted toward the folded ranges
  function automatic logic [15:0] pick_unit();
    int          k;
    logic [15:0] u;
    k = $urandom_range(0, 99);
    if (k < 20)      u = 16'hFF5F + 16'($urandom_range(0, 64));
    else if (k < 32) u = 16'hFF01 + 16'($urandom_range(0, 93));
    else if (k < 38) u = 16'hFFA0 + 16'($urandom_range(0, 63));
    else if (k < 46) u = 16'hFFE0 + 16'($urandom_range(0, 15));
    else if (k < 52) u = 16'h0000;
    else if (k < 58) u = ($urandom_range(0, 1) == 0) ? 16'hFF00 :
                         16'hFFF0 + 16'($urandom_range(0, 15));
    else if (k < 70) u = 16'h0020 + 16'($urandom_range(0, 94));
    else if (k < 78) u = pick_base();
    else             u = 16'($urandom_range(0, 65535));
    return u;
  endfunction

  // result side: random stalls, one long hold-off to back up the block
  initial begin : drain
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_taken == 200 && !long_hold_done) begin
        stall = 300;
        long_hold_done = 1'b1;
      end else begin
        stall = draw_gap(recv_mode);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
      if (results_taken % 64 == 0) recv_mode = idle_mode_e'($urandom_range(0, 2));
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int str_len;
    int i;
    in_valid  <= 1'b0;
    code_unit <= '0;
    last_unit <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty string: end marker only
    send_unit(16'h0000, 1'b1);
    // range edges, lone marks, unassigned misc slot, units past the table
    send_unit(16'hFF01, 1'b0);
    send_unit(16'hFF5E, 1'b0);
    send_unit(16'hFF5F, 1'b0);
    send_unit(MarkSemi, 1'b0);
    send_unit(MarkVoiced, 1'b0);
    send_unit(16'hFFE7, 1'b0);
    send_unit(16'hFFEE, 1'b0);
    send_unit(16'hFFEF, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // merge on the last unit
    send_unit(16'hFF76, 1'b0);
    send_unit(MarkVoiced, 1'b1);
    // semi-voiced merge and one of the single voiced bases
    send_unit(16'hFF8A, 1'b0);
    send_unit(MarkSemi, 1'b0);
    send_unit(BaseWa, 1'b0);
    send_unit(MarkVoiced, 1'b0);
    // pair not listed: base flushed, mark folded on its own
    send_unit(16'hFF76, 1'b0);
    send_unit(MarkSemi, 1'b0);
    // zero unit keeps base and mark apart
    send_unit(16'hFF84, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(MarkVoiced, 1'b0);
    // base as last unit is not held
    send_unit(16'hFF8E, 1'b1);
    // trailing zero: flag goes on the flushed base
    send_unit(16'hFF77, 1'b0);
    send_unit(16'h0000, 1'b1);

    // random strings, many of them base-mark pairs
    while (units_sent < 1650) begin
      str_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      i = 0;
      while (i < str_len) begin
        if (i < str_len - 1 && $urandom_range(0, 99) < 30) begin
          send_unit(pick_base(), 1'b0);
          send_unit(($urandom_range(0, 3) == 0) ? MarkSemi : MarkVoiced, i + 2 == str_len);
          i += 2;
        end else begin
          send_unit(pick_unit(), i + 1 == str_len);
          i++;
        end
      end
    end
    in_valid <= 1'b0;

    // drain, then a few quiet cycles to catch stray results
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
